// ===== sv/gregorian_date_arithmetic_macros.svh =====
// Assertion macros used by the date arithmetic checker
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH

// same-cycle implication, disabled during reset
`define GDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gda_pkg.sv =====
// Types, constants and calendar helper functions for the date arithmetic unit
`timescale 1ns / 1ps

package gda_pkg;

   localparam int YW   = 14;
   localparam int MW   = 4;
   localparam int DW   = 5;
   localparam int NW   = 16;
   localparam int DIFW = 22;
   localparam int DYW  = 9;
   localparam int DOEW = 18;
   localparam int ERAW = 6;
   localparam int YOEW = 9;

   localparam int DN_MAX = 3652364;

   localparam logic [YW-1:0] YEAR_MIN  = 14'd1;
   localparam logic [YW-1:0] YEAR_MAX  = 14'd9999;
   localparam logic [MW-1:0] MONTH_MIN = 4'd1;
   localparam logic [MW-1:0] MONTH_FEB = 4'd2;
   localparam logic [MW-1:0] MONTH_MAX = 4'd12;
   localparam logic [DW-1:0] DAY_MIN   = 5'd1;

   localparam logic [DOEW-1:0] D_400    = 18'd400;
   localparam logic [DOEW-1:0] D_100    = 18'd100;
   localparam logic [DOEW-1:0] D_153    = 18'd153;
   localparam logic [DOEW-1:0] D_365    = 18'd365;
   localparam logic [DOEW-1:0] D_1460   = 18'd1460;
   localparam logic [DOEW-1:0] D_36524  = 18'd36524;
   localparam logic [DOEW-1:0] D_146096 = 18'd146096;
   localparam logic [DOEW-1:0] D_146097 = 18'd146097;

   localparam logic [YW-1:0] INV_25     = 14'd7209;
   localparam logic [YW-1:0] DIV25_LIM  = 14'd655;

   localparam logic [DW-1:0] MONTH_LEN [13] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   localparam logic [DYW-1:0] MP_DAYS [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEC  = 2'd1,
      OP_DIFF = 2'd2,
      OP_CMP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      DV_400, DV_100, DV_153, DV_365, DV_1460, DV_36524, DV_146096, DV_146097
   } div_type;

   typedef enum logic [4:0] {
      STP_YA400, STP_YA100, STP_DOE_A, STP_DN_A,
      STP_YB400, STP_YB100, STP_DOE_B, STP_DN_B,
      STP_OP,
      STP_DIV_Z, STP_DIV_1460, STP_DIV_36524, STP_DIV_146096,
      STP_DIV_365, STP_DIV_YC, STP_DOY, STP_DIV_MP, STP_RES
   } step_type;

   typedef struct packed {
      logic     load;
      logic     go;
      logic     wr;
      step_type step;
   } gda_cmd_type;

   typedef struct packed {
      logic div_done;
      logic convert;
   } gda_stat_type;

   typedef struct packed {
      logic [YW-1:0]  y;
      logic [YW-1:0]  yy;
      logic [DYW-1:0] doy;
   } prep_type;

   function automatic logic is_leap(input logic [YW-1:0] y);
      logic [YW-1:0] p;
      logic          div4;
      logic          div16;
      logic          div25;
      p     = y * INV_25;
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      div25 = (p <= DIV25_LIM);
      return (div4 && !div25) || (div16 && div25);
   endfunction

   function automatic prep_type date_prep(input logic [YW-1:0] yi,
                                          input logic [MW-1:0] mi,
                                          input logic [DW-1:0] di);
      logic [YW-1:0] y;
      logic [MW-1:0] m;
      logic [DW-1:0] d;
      logic [DW-1:0] len;
      logic [MW-1:0] mp;
      prep_type      p;
      y = (yi < YEAR_MIN) ? YEAR_MIN : ((yi > YEAR_MAX) ? YEAR_MAX : yi);
      m = (mi < MONTH_MIN) ? MONTH_MIN : ((mi > MONTH_MAX) ? MONTH_MAX : mi);
      len = MONTH_LEN[m] + DW'((m == MONTH_FEB) && is_leap(y));
      d = (di < DAY_MIN) ? DAY_MIN : ((di > len) ? len : di);
      mp = (m > MONTH_FEB) ? m - 4'd3 : m + 4'd9;
      p.y   = y;
      p.yy  = (m <= MONTH_FEB) ? y - 14'd1 : y;
      p.doy = MP_DAYS[mp] + DYW'(d) - 9'd1;
      return p;
   endfunction

endpackage

// ===== sv/gda_divc.sv =====
// Divider by a selectable constant using reciprocal multiplication
`timescale 1ns / 1ps

module gda_divc import gda_pkg::*; #(
   parameter int XW = 22
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  div_type       sel,
   input  logic [XW-1:0] x,
   output logic          done,
   output logic [XW-1:0] q,
   output logic [XW-1:0] r
);

   localparam int S_400    = XW + $clog2(400);
   localparam int S_100    = XW + $clog2(100);
   localparam int S_153    = XW + $clog2(153);
   localparam int S_365    = XW + $clog2(365);
   localparam int S_1460   = XW + $clog2(1460);
   localparam int S_36524  = XW + $clog2(36524);
   localparam int S_146096 = XW + $clog2(146096);
   localparam int S_146097 = XW + $clog2(146097);

   localparam logic [XW:0] R_400    = (XW+1)'((64'd1 << S_400) / 64'd400);
   localparam logic [XW:0] R_100    = (XW+1)'((64'd1 << S_100) / 64'd100);
   localparam logic [XW:0] R_153    = (XW+1)'((64'd1 << S_153) / 64'd153);
   localparam logic [XW:0] R_365    = (XW+1)'((64'd1 << S_365) / 64'd365);
   localparam logic [XW:0] R_1460   = (XW+1)'((64'd1 << S_1460) / 64'd1460);
   localparam logic [XW:0] R_36524  = (XW+1)'((64'd1 << S_36524) / 64'd36524);
   localparam logic [XW:0] R_146096 = (XW+1)'((64'd1 << S_146096) / 64'd146096);
   localparam logic [XW:0] R_146097 = (XW+1)'((64'd1 << S_146097) / 64'd146097);

   localparam int PW = 2 * XW + 1;

   logic [XW-1:0]   x_ff;
   div_type         sel_ff;
   logic [PW-1:0]   prod_ff, prod_in;
   logic            v1_ff;
   logic            v2_ff;
   logic [XW-1:0]   qe_ff, qe_in;
   logic [XW-1:0]   qd_ff, qd_in;
   logic [XW:0]     recip;
   logic [6:0]      shamt;
   logic [DOEW-1:0] dsel;
   logic [XW-1:0]   rem;
   logic            fix;

   always_comb begin
      case (sel)
         DV_400:    recip = R_400;
         DV_100:    recip = R_100;
         DV_153:    recip = R_153;
         DV_365:    recip = R_365;
         DV_1460:   recip = R_1460;
         DV_36524:  recip = R_36524;
         DV_146096: recip = R_146096;
         DV_146097: recip = R_146097;
         default:   recip = R_146097;
      endcase
   end

   always_comb begin
      case (sel_ff)
         DV_400:    begin shamt = 7'(S_400);    dsel = D_400;    end
         DV_100:    begin shamt = 7'(S_100);    dsel = D_100;    end
         DV_153:    begin shamt = 7'(S_153);    dsel = D_153;    end
         DV_365:    begin shamt = 7'(S_365);    dsel = D_365;    end
         DV_1460:   begin shamt = 7'(S_1460);   dsel = D_1460;   end
         DV_36524:  begin shamt = 7'(S_36524);  dsel = D_36524;  end
         DV_146096: begin shamt = 7'(S_146096); dsel = D_146096; end
         DV_146097: begin shamt = 7'(S_146097); dsel = D_146097; end
         default:   begin shamt = 7'(S_146097); dsel = D_146097; end
      endcase
   end

   assign prod_in = PW'(x) * PW'(recip);
   assign qe_in   = XW'(prod_ff >> shamt);
   assign qd_in   = XW'(qe_in * XW'(dsel));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         x_ff    <= x;
         sel_ff  <= sel;
         prod_ff <= prod_in;
      end
      if (v1_ff) begin
         qe_ff <= qe_in;
         qd_ff <= qd_in;
      end
   end

   assign rem  = x_ff - qd_ff;
   assign fix  = (rem >= XW'(dsel));
   assign q    = fix ? qe_ff + XW'(1) : qe_ff;
   assign r    = fix ? rem - XW'(dsel) : rem;
   assign done = v2_ff;

endmodule

// ===== sv/gda_dp.sv =====
// Datapath: operand registers, day-number arithmetic and result registers
`timescale 1ns / 1ps

module gda_dp import gda_pkg::*; #(
   parameter int MAX_ADD_DAYS = 65535,
   parameter int ZW           = 22
) (
   input  logic             clock,
   input  gda_cmd_type      cmd,
   output gda_stat_type     stat,
   input  logic [1:0]       req_opcode,
   input  logic [YW-1:0]    req_year_a,
   input  logic [MW-1:0]    req_month_a,
   input  logic [DW-1:0]    req_day_a,
   input  logic [YW-1:0]    req_year_b,
   input  logic [MW-1:0]    req_month_b,
   input  logic [DW-1:0]    req_day_b,
   input  logic [NW-1:0]    req_day_count,
   output logic [YW-1:0]    rsp_res_year,
   output logic [MW-1:0]    rsp_res_month,
   output logic [DW-1:0]    rsp_res_day,
   output logic [DIFW-1:0]  rsp_day_difference,
   output logic             rsp_is_equal,
   output logic             rsp_is_greater,
   output logic             rsp_is_less,
   output logic             rsp_order_error
);

   opcode_type      op_ff;
   logic [ZW-1:0]   n_ff;
   logic [YW-1:0]   ya_ff, yb_ff, yya_ff, yyb_ff;
   logic [DYW-1:0]  doya_ff, doyb_ff, doy_ff;
   logic [ERAW-1:0] era_ff;
   logic [YOEW-1:0] yoe_ff;
   logic [1:0]      hq_ff;
   logic [DOEW-1:0] doe_ff, acc_ff;
   logic [ZW-1:0]   na_ff, nb_ff, z_ff;
   logic [MW-1:0]   mp_ff;
   logic [YW-1:0]   ry_ff;
   logic [MW-1:0]   rm_ff;
   logic [DW-1:0]   rd_ff;
   logic [DIFW-1:0] diff_ff;
   logic            eq_ff, gt_ff, lt_ff, err_ff;

   prep_type        pa, pb;
   logic [ZW-1:0]   n_in;
   div_type         dsel;
   logic [ZW-1:0]   dx;
   logic            ddone;
   logic [ZW-1:0]   dq, dr;
   logic [DOEW-1:0] yoe_days;
   logic [DOEW-1:0] doe_calc;
   logic [ZW-1:0]   dn_calc;
   logic [MW-1:0]   mm;

   assign pa   = date_prep(req_year_a, req_month_a, req_day_a);
   assign pb   = date_prep(req_year_b, req_month_b, req_day_b);
   assign n_in = (ZW'(req_day_count) > ZW'(MAX_ADD_DAYS)) ? ZW'(MAX_ADD_DAYS)
                                                          : ZW'(req_day_count);

   always_comb begin
      case (cmd.step)
         STP_YA400:      begin dsel = DV_400;    dx = ZW'(yya_ff); end
         STP_YB400:      begin dsel = DV_400;    dx = ZW'(yyb_ff); end
         STP_YA100,
         STP_YB100,
         STP_DIV_YC:     begin dsel = DV_100;    dx = ZW'(yoe_ff); end
         STP_DIV_Z:      begin dsel = DV_146097; dx = z_ff; end
         STP_DIV_1460:   begin dsel = DV_1460;   dx = ZW'(doe_ff); end
         STP_DIV_36524:  begin dsel = DV_36524;  dx = ZW'(doe_ff); end
         STP_DIV_146096: begin dsel = DV_146096; dx = ZW'(doe_ff); end
         STP_DIV_365:    begin dsel = DV_365;    dx = ZW'(acc_ff); end
         STP_DIV_MP:     begin dsel = DV_153;    dx = ZW'(doy_ff) * ZW'(5) + ZW'(2); end
         default:        begin dsel = DV_400;    dx = ZW'(yya_ff); end
      endcase
   end

   gda_divc #(.XW(ZW)) u_divc (
      .clock (clock),
      .reset (1'b0),
      .go    (cmd.go),
      .sel   (dsel),
      .x     (dx),
      .done  (ddone),
      .q     (dq),
      .r     (dr)
   );

   assign yoe_days = DOEW'(yoe_ff) * D_365 + DOEW'(yoe_ff >> 2) - DOEW'(hq_ff);
   assign doe_calc = yoe_days + DOEW'((cmd.step == STP_DOE_A) ? doya_ff : doyb_ff);
   assign dn_calc  = ZW'(era_ff) * ZW'(D_146097) + ZW'(doe_ff);
   assign mm       = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_opcode);
         n_ff    <= n_in;
         ya_ff   <= pa.y;
         yya_ff  <= pa.yy;
         doya_ff <= pa.doy;
         yb_ff   <= pb.y;
         yyb_ff  <= pb.yy;
         doyb_ff <= pb.doy;
         ry_ff   <= '0;
         rm_ff   <= '0;
         rd_ff   <= '0;
         diff_ff <= '0;
         eq_ff   <= 1'b0;
         gt_ff   <= 1'b0;
         lt_ff   <= 1'b0;
         err_ff  <= 1'b0;
      end else if (cmd.wr) begin
         case (cmd.step)
            STP_YA400,
            STP_YB400: begin
               era_ff <= ERAW'(dq);
               yoe_ff <= YOEW'(dr);
            end
            STP_YA100,
            STP_YB100,
            STP_DIV_YC:     hq_ff <= 2'(dq);
            STP_DOE_A,
            STP_DOE_B:      doe_ff <= doe_calc;
            STP_DN_A:       na_ff <= dn_calc;
            STP_DN_B:       nb_ff <= dn_calc;
            STP_OP: begin
               case (op_ff)
                  OP_ADD: z_ff <= na_ff + n_ff;
                  OP_DEC: z_ff <= na_ff - ZW'(1);
                  OP_DIFF: begin
                     if (ya_ff < yb_ff) begin
                        err_ff <= 1'b1;
                     end else begin
                        diff_ff <= (na_ff >= nb_ff) ? DIFW'(na_ff - nb_ff)
                                                    : DIFW'(nb_ff - na_ff);
                     end
                  end
                  OP_CMP: begin
                     eq_ff <= (na_ff == nb_ff);
                     gt_ff <= (na_ff > nb_ff);
                     lt_ff <= (na_ff < nb_ff);
                  end
                  default: z_ff <= na_ff;
               endcase
            end
            STP_DIV_Z: begin
               era_ff <= ERAW'(dq);
               doe_ff <= DOEW'(dr);
               acc_ff <= DOEW'(dr);
            end
            STP_DIV_1460:   acc_ff <= acc_ff - DOEW'(dq);
            STP_DIV_36524:  acc_ff <= acc_ff + DOEW'(dq);
            STP_DIV_146096: acc_ff <= acc_ff - DOEW'(dq);
            STP_DIV_365:    yoe_ff <= YOEW'(dq);
            STP_DOY:        doy_ff <= DYW'(doe_ff - yoe_days);
            STP_DIV_MP:     mp_ff <= MW'(dq);
            STP_RES: begin
               rm_ff <= mm;
               rd_ff <= DW'(doy_ff - MP_DAYS[mp_ff] + 9'd1);
               ry_ff <= YW'(yoe_ff) + YW'(era_ff) * YW'(D_400)
                        + YW'(mm <= MONTH_FEB);
            end
            default: hq_ff <= hq_ff;
         endcase
      end
   end

   assign stat.div_done = ddone;
   assign stat.convert  = (op_ff == OP_ADD) || (op_ff == OP_DEC);

   assign rsp_res_year       = ry_ff;
   assign rsp_res_month      = rm_ff;
   assign rsp_res_day        = rd_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_is_equal       = eq_ff;
   assign rsp_is_greater     = gt_ff;
   assign rsp_is_less        = lt_ff;
   assign rsp_order_error    = err_ff;

endmodule

// ===== sv/gda_ctrl.sv =====
// Controller: sequences the datapath steps for one request
`timescale 1ns / 1ps

module gda_ctrl import gda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  gda_stat_type stat,
   output gda_cmd_type  cmd,
   output logic         busy,
   output logic         rsp_strobe
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      last;
   step_type  nxt;
   logic      is_div;

   always_comb begin
      case (step_ff)
         STP_YA400:      nxt = STP_YA100;
         STP_YA100:      nxt = STP_DOE_A;
         STP_DOE_A:      nxt = STP_DN_A;
         STP_DN_A:       nxt = STP_YB400;
         STP_YB400:      nxt = STP_YB100;
         STP_YB100:      nxt = STP_DOE_B;
         STP_DOE_B:      nxt = STP_DN_B;
         STP_DN_B:       nxt = STP_OP;
         STP_OP:         nxt = STP_DIV_Z;
         STP_DIV_Z:      nxt = STP_DIV_1460;
         STP_DIV_1460:   nxt = STP_DIV_36524;
         STP_DIV_36524:  nxt = STP_DIV_146096;
         STP_DIV_146096: nxt = STP_DIV_365;
         STP_DIV_365:    nxt = STP_DIV_YC;
         STP_DIV_YC:     nxt = STP_DOY;
         STP_DOY:        nxt = STP_DIV_MP;
         STP_DIV_MP:     nxt = STP_RES;
         default:        nxt = STP_YA400;
      endcase
   end

   always_comb begin
      case (step_ff)
         STP_DOE_A, STP_DN_A, STP_DOE_B, STP_DN_B,
         STP_OP, STP_DOY, STP_RES: is_div = 1'b0;
         default:                  is_div = 1'b1;
      endcase
   end

   assign last = (step_ff == STP_RES) || ((step_ff == STP_OP) && !stat.convert);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '{load: 1'b0, go: 1'b0, wr: 1'b0, step: step_ff};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = STP_YA400;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_div) begin
               cmd.go   = 1'b1;
               state_in = ST_WAIT;
            end else begin
               cmd.wr   = 1'b1;
               state_in = last ? ST_DONE : ST_EXEC;
               step_in  = last ? step_ff : nxt;
            end
         end
         ST_WAIT: begin
            if (stat.div_done) begin
               cmd.wr   = 1'b1;
               state_in = ST_EXEC;
               step_in  = nxt;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STP_YA400;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

endmodule

// ===== sv/gregorian_date_arithmetic.sv =====
// Top level of the Gregorian date arithmetic unit
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; one result follows
// on the rsp_ ports for a single cycle under rsp_strobe, which cannot be held
// off, so capture it on that cycle. Add and decrement run longer than
// difference and compare, since they also convert the day number back to a
// date. Their run time is set by the single shared constant divider, which
// is used for two divisions per date and seven for the conversion back.
// Unused result fields read as zero.
module gregorian_date_arithmetic import gda_pkg::*; #(
   parameter int MAX_ADD_DAYS = 65535
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_opcode,
   input  logic [YW-1:0]   req_year_a,
   input  logic [MW-1:0]   req_month_a,
   input  logic [DW-1:0]   req_day_a,
   input  logic [YW-1:0]   req_year_b,
   input  logic [MW-1:0]   req_month_b,
   input  logic [DW-1:0]   req_day_b,
   input  logic [NW-1:0]   req_day_count,
   output logic            rsp_strobe,
   output logic [YW-1:0]   rsp_res_year,
   output logic [MW-1:0]   rsp_res_month,
   output logic [DW-1:0]   rsp_res_day,
   output logic [DIFW-1:0] rsp_day_difference,
   output logic            rsp_is_equal,
   output logic            rsp_is_greater,
   output logic            rsp_is_less,
   output logic            rsp_order_error
);

   localparam int ZW = $clog2(DN_MAX + MAX_ADD_DAYS + 1);

   gda_cmd_type  cmd;
   gda_stat_type stat;

   gda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   gda_dp #(.MAX_ADD_DAYS(MAX_ADD_DAYS), .ZW(ZW)) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_year_a         (req_year_a),
      .req_month_a        (req_month_a),
      .req_day_a          (req_day_a),
      .req_year_b         (req_year_b),
      .req_month_b        (req_month_b),
      .req_day_b          (req_day_b),
      .req_day_count      (req_day_count),
      .rsp_res_year       (rsp_res_year),
      .rsp_res_month      (rsp_res_month),
      .rsp_res_day        (rsp_res_day),
      .rsp_day_difference (rsp_day_difference),
      .rsp_is_equal       (rsp_is_equal),
      .rsp_is_greater     (rsp_is_greater),
      .rsp_is_less        (rsp_is_less),
      .rsp_order_error    (rsp_order_error)
   );

endmodule

// ===== sv/gda_checker.sv =====
// Port-level checker for the date arithmetic unit, bound to the top level
`timescale 1ns / 1ps
`include "gregorian_date_arithmetic_macros.svh"

module gda_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   `GDA_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy, "result outside busy")
   `GDA_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy, "transfer not taken")
   `GDA_ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe, "no idle")
   `GDA_ASSERT_SAME(a_fell_strobe, clock, reset, $fell(busy), $past(rsp_strobe), "lost result")

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
